### src/drhen_pkg.sv
// Shared widths and constants for the decimal round-half-even normalizer.
`default_nettype none
package drhen_pkg;

   localparam int LIMB_W         = 32;
   localparam int DIGIT_W        = 4;
   localparam int SCALE_W        = 6;
   localparam int SCALE_OUT_W    = 5;
   localparam int IN_LIMBS       = 6;
   localparam int KEEP_LIMBS     = 3;
   localparam int WORK_WORDS_DEF = 6;
   localparam int MAX_SCALE_DEF  = 28;

   // 2^32 = 10 * LIMB_QUOT10 + LIMB_REM10
   localparam logic [LIMB_W-1:0]  LIMB_QUOT10 = 32'd429496729;
   localparam logic [LIMB_W:0]    LIMB_REM10  = 33'd6;
   // x / 5 == (x * RECIP5) >> 34 for any 32-bit x
   localparam logic [LIMB_W-1:0]  RECIP5      = 32'hCCCCCCCD;
   localparam int                 RECIP5_SHIFT = 34;
   localparam logic [DIGIT_W-1:0] HALF_DIGIT  = 4'd5;

endpackage : drhen_pkg
`default_nettype wire

### src/drhen_div10_step.sv
// One limb of a long division by ten: remainder in, quotient limb and remainder out.
`default_nettype none
module drhen_div10_step
   import drhen_pkg::*;
(
   input  wire logic [DIGIT_W-1:0] rem_i,
   input  wire logic [LIMB_W-1:0]  limb_i,
   output logic      [LIMB_W-1:0]  quot_o,
   output logic      [DIGIT_W-1:0] rem_o
);

   logic [LIMB_W:0]         part;
   logic [LIMB_W-1:0]       half;
   logic [2*LIMB_W-1:0]     prod;
   logic [LIMB_W-3:0]       q_lo;
   logic [LIMB_W+DIGIT_W-1:0] hi_part;
   logic [LIMB_W:0]         back;
   logic [LIMB_W:0]         diff;

   // rem*2^32 + limb = rem*10*LIMB_QUOT10 + (rem*LIMB_REM10 + limb)
   always_comb begin
      part    = {{(LIMB_W-DIGIT_W+1){1'b0}}, rem_i} * LIMB_REM10 + {1'b0, limb_i};
      half    = part[LIMB_W:1];
      prod    = {{LIMB_W{1'b0}}, half} * {{LIMB_W{1'b0}}, RECIP5};
      q_lo    = prod[RECIP5_SHIFT +: (LIMB_W-2)];
      hi_part = {{LIMB_W{1'b0}}, rem_i} * {{DIGIT_W{1'b0}}, LIMB_QUOT10};
      quot_o  = hi_part[LIMB_W-1:0] + {2'b00, q_lo};
      back    = {q_lo, 3'b000} + {2'b00, q_lo, 1'b0};
      diff    = part - back;
      rem_o   = diff[DIGIT_W-1:0];
   end

endmodule : drhen_div10_step
`default_nettype wire

### src/decimal_round_half_even_normalize.sv
// Top level: fits a wide decimal mantissa into 96 bits with round-half-even and zero stripping.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | mantissa words 0..2, scale_in
//   rsp     | out       | rsp_valid/rsp_stall  | result_low, result_high, scale_out, overflow
//
// One item is worked at a time; req_stall stays high from acceptance until the result
// is loaded into the output register. Each division by ten runs through the shared
// limb divider one limb per cycle. Synchronous reset clears the sequencer and the
// output valid. A stalled result holds in the output register while the next item is
// already accepted and worked.
`default_nettype none
module decimal_round_half_even_normalize
   import drhen_pkg::*;
#(
   parameter int WORK_WORDS = WORK_WORDS_DEF,
   parameter int MAX_SCALE  = MAX_SCALE_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [63:0]            req_mantissa_word0,
   input  wire logic [63:0]            req_mantissa_word1,
   input  wire logic [63:0]            req_mantissa_word2,
   input  wire logic [SCALE_W-1:0]     req_scale_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [63:0]                 rsp_result_low,
   output logic [31:0]                 rsp_result_high,
   output logic [SCALE_OUT_W-1:0]      rsp_scale_out,
   output logic                        rsp_overflow
);

   localparam int CNT_W  = $clog2(WORK_WORDS);
   localparam int WIDE_W = WORK_WORDS * LIMB_W;
   localparam logic [CNT_W-1:0]   LAST_CNT  = CNT_W'(WORK_WORDS - 1);
   localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(MAX_SCALE);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SHRINK, ST_DIV, ST_ROUND, ST_FIX, ST_BUMP, ST_STRIP, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      JOB_SHRINK, JOB_CARRY, JOB_STRIP
   } job_type;

   state_type            state_ff, state_in;
   job_type              job_ff, job_in;
   logic [LIMB_W-1:0]    limb_ff [WORK_WORDS];
   logic [LIMB_W-1:0]    limb_in [WORK_WORDS];
   logic [LIMB_W-1:0]    quot_ff [WORK_WORDS];
   logic [LIMB_W-1:0]    quot_in [WORK_WORDS];
   logic [LIMB_W-1:0]    load_limb [WORK_WORDS];
   logic [LIMB_W-1:0]    inc_limb [WORK_WORDS];
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SCALE_W-1:0]   scl_ff, scl_in;
   logic [DIGIT_W-1:0]   last_ff, last_in;
   logic                 prev_nz_ff, prev_nz_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_low_ff, rsp_low_in;
   logic [31:0]          rsp_high_ff, rsp_high_in;
   logic [SCALE_OUT_W-1:0] rsp_scale_ff, rsp_scale_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic [191:0]         wide_req;
   logic [WIDE_W-1:0]    flat, flat_inc;
   logic                 too_wide;
   logic                 must_shrink;
   logic                 round_up;
   logic [LIMB_W-1:0]    dig_q;
   logic [DIGIT_W-1:0]   dig_r;

   drhen_div10_step u_div10 (
      .rem_i  (rem_ff),
      .limb_i (limb_ff[WORK_WORDS-1]),
      .quot_o (dig_q),
      .rem_o  (dig_r)
   );

   assign wide_req = {req_mantissa_word2, req_mantissa_word1, req_mantissa_word0};

   // Input bits above the work width drop; missing limbs load as zero.
   for (genvar gi = 0; gi < WORK_WORDS; gi++) begin : g_load
      if (gi < IN_LIMBS) begin : g_take
         assign load_limb[gi] = wide_req[gi*LIMB_W +: LIMB_W];
      end else begin : g_zero
         assign load_limb[gi] = '0;
      end
   end

   always_comb begin
      too_wide = 1'b0;
      for (int i = KEEP_LIMBS; i < WORK_WORDS; i++) begin
         too_wide = too_wide | (limb_ff[i] != '0);
      end
      for (int i = 0; i < WORK_WORDS; i++) begin
         flat[i*LIMB_W +: LIMB_W] = limb_ff[i];
      end
      flat_inc = flat + {{(WIDE_W-1){1'b0}}, 1'b1};
      for (int i = 0; i < WORK_WORDS; i++) begin
         inc_limb[i] = flat_inc[i*LIMB_W +: LIMB_W];
      end
      must_shrink = too_wide || (scl_ff > SCALE_MAX);
      round_up = (last_ff > HALF_DIGIT) ||
                 ((last_ff == HALF_DIGIT) && (prev_nz_ff || limb_ff[0][0]));
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      limb_in      = limb_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      scl_in       = scl_ff;
      last_in      = last_ff;
      prev_nz_in   = prev_nz_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_scale_in = rsp_scale_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               limb_in    = load_limb;
               scl_in     = req_scale_in;
               last_in    = '0;
               prev_nz_in = 1'b0;
               ovf_in     = 1'b0;
               state_in   = ST_SHRINK;
            end
         end
         ST_SHRINK: begin
            if (must_shrink && (scl_ff != '0)) begin
               job_in   = JOB_SHRINK;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               ovf_in   = must_shrink;
               state_in = ST_ROUND;
            end
         end
         ST_DIV: begin
            // rotate limbs top to bottom, shift quotient limbs in from the bottom
            limb_in[0] = limb_ff[WORK_WORDS-1];
            quot_in[0] = dig_q;
            for (int i = 1; i < WORK_WORDS; i++) begin
               limb_in[i] = limb_ff[i-1];
               quot_in[i] = quot_ff[i-1];
            end
            rem_in = dig_r;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               unique case (job_ff)
                  JOB_SHRINK: begin
                     limb_in    = quot_in;
                     scl_in     = scl_ff - 1'b1;
                     prev_nz_in = prev_nz_ff | (last_ff != '0);
                     last_in    = dig_r;
                     state_in   = ST_SHRINK;
                  end
                  JOB_CARRY: begin
                     limb_in  = quot_in;
                     scl_in   = scl_ff - 1'b1;
                     state_in = ST_BUMP;
                  end
                  JOB_STRIP: begin
                     if (dig_r == '0) begin
                        limb_in  = quot_in;
                        scl_in   = scl_ff - 1'b1;
                        state_in = ST_STRIP;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ROUND: begin
            if (ovf_ff) begin
               state_in = ST_DONE;
            end else if (round_up) begin
               limb_in  = inc_limb;
               state_in = ST_FIX;
            end else begin
               state_in = ST_STRIP;
            end
         end
         ST_FIX: begin
            // rounding carried to 2^96: drop one more digit, or give up
            if (too_wide) begin
               if (scl_ff != '0) begin
                  job_in   = JOB_CARRY;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_STRIP;
            end
         end
         ST_BUMP: begin
            limb_in  = inc_limb;
            state_in = ST_STRIP;
         end
         ST_STRIP: begin
            if (scl_ff != '0) begin
               job_in   = JOB_STRIP;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = ovf_ff;
               if (ovf_ff) begin
                  rsp_low_in   = '0;
                  rsp_high_in  = '0;
                  rsp_scale_in = '0;
               end else begin
                  rsp_low_in   = {limb_ff[1], limb_ff[0]};
                  rsp_high_in  = limb_ff[2];
                  rsp_scale_in = scl_ff[SCALE_OUT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff       <= job_in;
      limb_ff      <= limb_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      scl_ff       <= scl_in;
      last_ff      <= last_in;
      prev_nz_ff   <= prev_nz_in;
      ovf_ff       <= ovf_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_scale_ff <= rsp_scale_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_low  = rsp_low_ff;
   assign rsp_result_high = rsp_high_ff;
   assign rsp_scale_out   = rsp_scale_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule : decimal_round_half_even_normalize
`default_nettype wire

### sim/decimal_fit_checker.sv
// Checker for the decimal normalizer: predicts each result and compares it to what comes out.
module decimal_fit_checker
   import drhen_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [63:0]            req_mantissa_word0,
   input  logic [63:0]            req_mantissa_word1,
   input  logic [63:0]            req_mantissa_word2,
   input  logic [SCALE_W-1:0]     req_scale_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [63:0]            rsp_result_low,
   input  logic [31:0]            rsp_result_high,
   input  logic [SCALE_OUT_W-1:0] rsp_scale_out,
   input  logic                   rsp_overflow,
   output int                     mismatches,
   output int                     fits_waiting
);

   typedef struct packed {
      logic [63:0]            low;
      logic [31:0]            high;
      logic [SCALE_OUT_W-1:0] scale;
      logic                   ovf;
   } fit_type;

   fit_type fits_due[$];
   int      bad_fields = 0;

   // Fit a 192-bit mantissa into 96 bits: drop digits, round half to even, strip zeros.
   function automatic fit_type fit_decimal(input logic [191:0] mant,
                                           input logic [SCALE_W-1:0] sc);
      logic [191:0] v;
      logic [191:0] rem;
      logic [SCALE_W-1:0] s;
      logic [3:0] last;
      int nonzero;
      logic ovf;
      logic up;
      fit_type r;
      v = mant;
      s = sc;
      last = '0;
      nonzero = 0;
      while ((v[191:96] != '0 || s > MAX_SCALE_DEF) && s > 0) begin
         rem = v % 192'd10;
         last = rem[3:0];
         v = v / 192'd10;
         s = s - 1'b1;
         if (last != 0)
            nonzero++;
      end
      ovf = (v[191:96] != '0) || (s > MAX_SCALE_DEF);
      // sticky count includes the last digit itself, so an earlier nonzero digit means > 1
      up = (last > HALF_DIGIT) ||
           (last == HALF_DIGIT && (nonzero > 1 || v[0]));
      if (up && !ovf) begin
         v = v + 1'b1;
         // carry out of 96 bits: drop one more digit if the scale allows it
         if (v[191:96] != '0) begin
            if (s > 0) begin
               v = v / 192'd10 + 1'b1;
               s = s - 1'b1;
            end else begin
               ovf = 1'b1;
            end
         end
      end
      if (ovf) begin
         r = '{low: '0, high: '0, scale: '0, ovf: 1'b1};
      end else begin
         while (s > 0 && (v % 192'd10) == 0) begin
            v = v / 192'd10;
            s = s - 1'b1;
         end
         r = '{low: v[63:0], high: v[95:64], scale: s[SCALE_OUT_W-1:0], ovf: 1'b0};
      end
      return r;
   endfunction

   task automatic flag(input string what, input logic [63:0] want, input logic [63:0] seen);
      $display("%0t %s expected %h actual %h", $time, what, want, seen);
      bad_fields++;
   endtask

   always @(posedge clock) begin
      fit_type due;
      fit_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            fits_due.push_back(fit_decimal({req_mantissa_word2, req_mantissa_word1,
                                            req_mantissa_word0}, req_scale_in));
         if (rsp_valid && !rsp_stall) begin
            got = '{low: rsp_result_low, high: rsp_result_high,
                    scale: rsp_scale_out, ovf: rsp_overflow};
            if (fits_due.size() == 0) begin
               $display("%0t result beat with none expected: %h %h %0d %b", $time,
                        got.low, got.high, got.scale, got.ovf);
               bad_fields++;
            end else begin
               due = fits_due.pop_front();
               if (got.low != due.low)
                  flag("result_low", due.low, got.low);
               if (got.high != due.high)
                  flag("result_high", 64'(due.high), 64'(got.high));
               if (got.scale != due.scale)
                  flag("scale_out", 64'(due.scale), 64'(got.scale));
               if (got.ovf != due.ovf)
                  flag("overflow", 64'(due.ovf), 64'(got.ovf));
            end
         end
      end
      mismatches   <= bad_fields;
      fits_waiting <= fits_due.size();
   end

endmodule : decimal_fit_checker

### sim/tb.sv
// Testbench top: drives mantissa beats through the normalizer and reports the verdict.
module tb;
   import drhen_pkg::*;

   localparam logic [191:0] TWO96 = 192'd1 << 96;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [63:0]            req_mantissa_word0 = '0;
   logic [63:0]            req_mantissa_word1 = '0;
   logic [63:0]            req_mantissa_word2 = '0;
   logic [SCALE_W-1:0]     req_scale_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [63:0]            rsp_result_low;
   logic [31:0]            rsp_result_high;
   logic [SCALE_OUT_W-1:0] rsp_scale_out;
   logic                   rsp_overflow;

   int mismatches;
   int fits_waiting;
   int idle_pct = 0;
   int stall_pct = 0;

   always #4 clock = ~clock;

   decimal_round_half_even_normalize dut (.*);

   decimal_fit_checker fit_check (.*);

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   function automatic logic [191:0] pow10(input int k);
      logic [191:0] p;
      p = 192'd1;
      repeat (k) p = p * 192'd10;
      return p;
   endfunction

   function automatic logic [191:0] rand192();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   // Offer one mantissa beat, idle first at random, and hold it until accepted.
   task automatic offer(input logic [191:0] mant, input logic [SCALE_W-1:0] sc);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mantissa_word0 <= mant[63:0];
      req_mantissa_word1 <= mant[127:64];
      req_mantissa_word2 <= mant[191:128];
      req_scale_in       <= sc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      logic [191:0] mant;
      logic [191:0] m;
      logic [191:0] tail;
      logic [SCALE_W-1:0] sc;
      int k;
      int digit;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, extremes of width and scale
      offer('0, 0);
      offer('0, 63);
      offer('1, 0);
      offer('1, 63);
      offer(TWO96 - 1, 0);
      offer(TWO96 - 1, 28);
      offer(TWO96 - 1, 63);
      offer(TWO96, 0);
      offer(TWO96, 1);
      offer(1, 28);
      // half-even rounding: even keep, odd keep, above and below half, sticky tail
      offer(25, 29);
      offer(35, 29);
      offer(26, 29);
      offer(24, 29);
      offer(251, 30);
      offer(250, 30);
      // rounding carry past 96 bits, with and without room in the scale
      offer((TWO96 - 1) * 10 + 9, 1);
      offer((TWO96 - 1) * 10 + 9, 2);
      offer((TWO96 - 1) * 10 + 5, 2);
      // trailing zero strip
      offer(1000, 3);
      offer(1000, 2);
      offer(12300, 5);
      offer(10, 63);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         repeat (175) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  mant = rand192() >> $urandom_range(0, 191);
                  sc = SCALE_W'($urandom_range(0, 63));
               end
               4, 5: begin
                  // small value times a power of ten to drive zero stripping
                  m = rand192() >> $urandom_range(120, 191);
                  mant = m * pow10($urandom_range(0, 40));
                  sc = SCALE_W'($urandom_range(0, 63));
               end
               6, 7: begin
                  // scale above the cap forces exactly k+1 dropped digits, mostly a half
                  k = $urandom_range(0, 26);
                  m = rand192() >> $urandom_range(96, 191);
                  digit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 5;
                  tail = $urandom_range(0, 1) ? rand192() % pow10(k) : '0;
                  mant = (m * 10 + 192'(digit)) * pow10(k) + tail;
                  sc = SCALE_W'(29 + k);
               end
               8: begin
                  // just under 2^96 after dropping digits: carry and overflow edges
                  k = $urandom_range(0, 20);
                  m = TWO96 - 1 - 192'($urandom_range(0, 2));
                  mant = m * pow10(k + 1) + rand192() % pow10(k + 1);
                  sc = SCALE_W'($urandom_range(0, k + 3));
               end
               default: begin
                  mant = rand192() >> $urandom_range(96, 160);
                  sc = SCALE_W'($urandom_range(0, 28));
               end
            endcase
            offer(mant, sc);
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (fits_waiting != 0);
      repeat (500) @(posedge clock);
      if (mismatches == 0 && fits_waiting == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule : tb

### decimal_round_half_even_normalize.f
src/drhen_pkg.sv
src/drhen_div10_step.sv
src/decimal_round_half_even_normalize.sv
sim/decimal_fit_checker.sv
sim/tb.sv
